// ===== hw/rtl/grid_astar_path_search_top_defines.svh =====
// assertion macros for the grid path search block
// used by grid_astar_path_search_top, no other dependencies
`ifndef GRID_ASTAR_PATH_SEARCH_TOP_DEFINES_SVH
`define GRID_ASTAR_PATH_SEARCH_TOP_DEFINES_SVH

// same-cycle implication, sampled on the rising clock edge
`define GAPS_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("gaps assertion failed");

// next-cycle implication, sampled on the rising clock edge
`define GAPS_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("gaps assertion failed");

`endif

// ===== hw/rtl/gaps_pkg.sv =====
// shared types, codes and helpers for the grid path search block
// no dependencies
package gaps_pkg;

   localparam int DEF_GRID_ROWS = 32;
   localparam int DEF_GRID_COLS = 32;
   localparam int DEF_COST_BITS = 4;

   localparam int POS_W      = 5;
   localparam int OPC_W      = 2;
   localparam int IN_COST_W  = 4;
   localparam int CNT_W      = 11;
   localparam int PCOST_W    = 14;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 5;
   localparam int DIFF_W     = 7;

   localparam logic [CNT_W-1:0]   CNT_MAX   = '1;
   localparam logic [PCOST_W-1:0] PCOST_MAX = '1;

   localparam logic [OPC_W-1:0] OP_LOAD = 2'd0;
   localparam logic [OPC_W-1:0] OP_RUN  = 2'd1;
   localparam logic [OPC_W-1:0] OP_READ = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_START_ROW     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_START_COL     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GOAL_ROW      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GOAL_COL      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_START_PRESENT = 3'd4;

   localparam logic [1:0] DIR_UP    = 2'd0;
   localparam logic [1:0] DIR_DOWN  = 2'd1;
   localparam logic [1:0] DIR_LEFT  = 2'd2;
   localparam logic [1:0] DIR_RIGHT = 2'd3;

   typedef enum logic [1:0] {
      STAT_DONE_OK    = 2'd0,
      STAT_PATH_FOUND = 2'd1,
      STAT_NO_PATH    = 2'd2,
      STAT_NO_START   = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_INIT,
      S_IDLE,
      S_LOAD,
      S_READ,
      S_READ_WAIT,
      S_CLEAR,
      S_SEED,
      S_SCAN,
      S_EXPAND,
      S_NB_ISSUE,
      S_NB_WAIT,
      S_FIN_ISSUE,
      S_FIN_WAIT,
      S_BT_ISSUE,
      S_BT_WAIT
   } state_type;

   typedef struct packed {
      logic [POS_W-1:0] start_row;
      logic [POS_W-1:0] start_col;
      logic [POS_W-1:0] goal_row;
      logic [POS_W-1:0] goal_col;
      logic             start_present;
   } cfg_type;

   typedef struct packed {
      logic cell_we;
      logic score_we;
      logic parent_we;
      logic scored_we;
      logic open_we;
      logic path_we;
   } mem_we_type;

   function automatic logic [DIFF_W-1:0] abs_diff(input logic [DIFF_W-1:0] a,
                                                  input logic [DIFF_W-1:0] b);
      return (a > b) ? a - b : b - a;
   endfunction

endpackage

// ===== hw/rtl/gaps_store.sv =====
// per-cell storage: cost, wall, score, parent move and the three flag arrays
// one write address and one read address shared by all arrays; uses gaps_pkg
module gaps_store #(
   parameter int CELLS     = 1024,
   parameter int IDX_W     = 10,
   parameter int COST_BITS = 4,
   parameter int SCORE_W   = 14
) (
   input  logic                   clock,
   input  gaps_pkg::mem_we_type   we,
   input  logic [IDX_W-1:0]       waddr,
   input  logic [COST_BITS-1:0]   wr_cost,
   input  logic                   wr_wall,
   input  logic [SCORE_W-1:0]     wr_score,
   input  logic [1:0]             wr_parent,
   input  logic                   wr_scored,
   input  logic                   wr_open,
   input  logic                   wr_path,
   input  logic [IDX_W-1:0]       raddr,
   output logic [COST_BITS-1:0]   rd_cost,
   output logic                   rd_wall,
   output logic [SCORE_W-1:0]     rd_score,
   output logic [1:0]             rd_parent,
   output logic                   rd_scored,
   output logic                   rd_open,
   output logic                   rd_path
);
   import gaps_pkg::*;

   logic [COST_BITS-1:0] cost_mem   [CELLS];
   logic                 wall_mem   [CELLS];
   logic [SCORE_W-1:0]   score_mem  [CELLS];
   logic [1:0]           parent_mem [CELLS];
   logic                 scored_mem [CELLS];
   logic                 open_mem   [CELLS];
   logic                 path_mem   [CELLS];

   always_ff @(posedge clock) begin
      if (we.cell_we) begin
         cost_mem[waddr] <= wr_cost;
         wall_mem[waddr] <= wr_wall;
      end
      if (we.score_we) begin
         score_mem[waddr] <= wr_score;
      end
      if (we.parent_we) begin
         parent_mem[waddr] <= wr_parent;
      end
      if (we.scored_we) begin
         scored_mem[waddr] <= wr_scored;
      end
      if (we.open_we) begin
         open_mem[waddr] <= wr_open;
      end
      if (we.path_we) begin
         path_mem[waddr] <= wr_path;
      end
   end

   always_ff @(posedge clock) begin
      rd_cost   <= cost_mem[raddr];
      rd_wall   <= wall_mem[raddr];
      rd_score  <= score_mem[raddr];
      rd_parent <= parent_mem[raddr];
      rd_scored <= scored_mem[raddr];
      rd_open   <= open_mem[raddr];
      rd_path   <= path_mem[raddr];
   end

endmodule

// ===== hw/rtl/gaps_ctrl.sv =====
// sequencer for load, read and search items
// drives gaps_store through one read and one write port; uses gaps_pkg
module gaps_ctrl #(
   parameter int GRID_ROWS = 32,
   parameter int GRID_COLS = 32,
   parameter int CELLS     = 1024,
   parameter int IDX_W     = 10,
   parameter int COST_BITS = 4,
   parameter int SCORE_W   = 14
) (
   input  logic                            clock,
   input  logic                            reset,
   input  gaps_pkg::cfg_type               cfg,
   input  logic                            start,
   output logic                            busy,
   input  logic [gaps_pkg::OPC_W-1:0]      req_opcode,
   input  logic [gaps_pkg::POS_W-1:0]      req_cell_row,
   input  logic [gaps_pkg::POS_W-1:0]      req_cell_col,
   input  logic [gaps_pkg::IN_COST_W-1:0]  req_cell_cost,
   input  logic                            req_cell_blocked,
   output gaps_pkg::mem_we_type            we,
   output logic [IDX_W-1:0]                waddr,
   output logic [COST_BITS-1:0]            wr_cost,
   output logic                            wr_wall,
   output logic [SCORE_W-1:0]              wr_score,
   output logic [1:0]                      wr_parent,
   output logic                            wr_scored,
   output logic                            wr_open,
   output logic                            wr_path,
   output logic [IDX_W-1:0]                raddr,
   input  logic [COST_BITS-1:0]            rd_cost,
   input  logic                            rd_wall,
   input  logic [SCORE_W-1:0]              rd_score,
   input  logic [1:0]                      rd_parent,
   input  logic                            rd_scored,
   input  logic                            rd_open,
   input  logic                            rd_path,
   output logic                            rsp_strobe,
   output logic [1:0]                      rsp_status,
   output logic [gaps_pkg::CNT_W-1:0]      rsp_visited_count,
   output logic [gaps_pkg::CNT_W-1:0]      rsp_path_length,
   output logic [gaps_pkg::PCOST_W-1:0]    rsp_path_cost,
   output logic [gaps_pkg::POS_W-1:0]      rsp_parent_row,
   output logic [gaps_pkg::POS_W-1:0]      rsp_parent_col,
   output logic                            rsp_has_parent,
   output logic                            rsp_on_path
);
   import gaps_pkg::*;

   localparam int RW  = $clog2(GRID_ROWS);
   localparam int CW  = $clog2(GRID_COLS);
   localparam int F_W = SCORE_W + 8;
   localparam logic [RW-1:0]    LAST_ROW = RW'(GRID_ROWS - 1);
   localparam logic [CW-1:0]    LAST_COL = CW'(GRID_COLS - 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CELLS - 1);
   localparam logic [IDX_W-1:0] COLS_IDX = IDX_W'(GRID_COLS);
   localparam logic [IDX_W:0]   STEP_MAX = (IDX_W+1)'(CELLS);

   state_type              state_ff, state_in;
   logic [OPC_W-1:0]       op_ff, op_in;
   logic [POS_W-1:0]       row_ff, row_in, col_ff, col_in;
   logic [IN_COST_W-1:0]   cost_ff, cost_in;
   logic                   wall_ff, wall_in;
   logic [IDX_W-1:0]       sc_idx_ff, sc_idx_in;
   logic [RW-1:0]          sc_row_ff, sc_row_in;
   logic [CW-1:0]          sc_col_ff, sc_col_in;
   logic                   iss_done_ff, iss_done_in;
   logic                   dv_ff, dv_in;
   logic [IDX_W-1:0]       d_idx_ff, d_idx_in;
   logic [RW-1:0]          d_row_ff, d_row_in;
   logic [CW-1:0]          d_col_ff, d_col_in;
   logic                   found_ff, found_in;
   logic [IDX_W-1:0]       best_idx_ff, best_idx_in;
   logic [RW-1:0]          best_row_ff, best_row_in;
   logic [CW-1:0]          best_col_ff, best_col_in;
   logic [F_W-1:0]         best_f_ff, best_f_in;
   logic [SCORE_W-1:0]     best_g_ff, best_g_in;
   logic [1:0]             dir_ff, dir_in;
   logic [IDX_W-1:0]       nb_idx_ff, nb_idx_in;
   logic [CNT_W-1:0]       visited_ff, visited_in;
   logic [CNT_W-1:0]       plen_ff, plen_in;
   logic [PCOST_W-1:0]     pcost_ff, pcost_in;
   logic [IDX_W-1:0]       cur_idx_ff, cur_idx_in;
   logic [RW-1:0]          cur_row_ff, cur_row_in;
   logic [CW-1:0]          cur_col_ff, cur_col_in;
   logic [IDX_W:0]         steps_ff, steps_in;
   logic                   rsp_strobe_ff, rsp_strobe_in;
   logic [1:0]             rsp_status_ff, rsp_status_in;
   logic [CNT_W-1:0]       rsp_visited_ff, rsp_visited_in;
   logic [CNT_W-1:0]       rsp_plen_ff, rsp_plen_in;
   logic [PCOST_W-1:0]     rsp_pcost_ff, rsp_pcost_in;
   logic [POS_W-1:0]       rsp_prow_ff, rsp_prow_in, rsp_pcol_ff, rsp_pcol_in;
   logic                   rsp_hasp_ff, rsp_hasp_in;
   logic                   rsp_onp_ff, rsp_onp_in;

   logic                   item_in_grid, start_ok, goal_in;
   logic [IDX_W-1:0]       item_idx, start_idx, goal_idx;
   logic [F_W-1:0]         scan_f;
   logic [SCORE_W-1:0]     trial_g;
   logic                   special;
   logic                   nb_ok;
   logic [IDX_W-1:0]       nb_idx;
   logic                   bt_ok;
   logic [IDX_W-1:0]       bt_idx;
   logic [RW-1:0]          bt_row;
   logic [CW-1:0]          bt_col;
   logic                   rd_parent_ok;
   logic [POS_W-1:0]       rd_prow, rd_pcol;
   logic                   is_start_cell;
   logic                   respond;
   status_type             resp_status;

   assign item_in_grid = (int'(row_ff) < GRID_ROWS) && (int'(col_ff) < GRID_COLS);
   assign item_idx     = IDX_W'(int'(row_ff) * GRID_COLS + int'(col_ff));
   assign start_ok     = cfg.start_present && (int'(cfg.start_row) < GRID_ROWS) &&
                         (int'(cfg.start_col) < GRID_COLS);
   assign start_idx    = IDX_W'(int'(cfg.start_row) * GRID_COLS + int'(cfg.start_col));
   assign goal_in      = (int'(cfg.goal_row) < GRID_ROWS) && (int'(cfg.goal_col) < GRID_COLS);
   assign goal_idx     = IDX_W'(int'(cfg.goal_row) * GRID_COLS + int'(cfg.goal_col));

   // f = g plus manhattan distance of the cell coming back from the sweep
   assign scan_f = F_W'(rd_score) +
                   F_W'(abs_diff(DIFF_W'(d_row_ff), DIFF_W'(cfg.goal_row))) +
                   F_W'(abs_diff(DIFF_W'(d_col_ff), DIFF_W'(cfg.goal_col)));

   assign trial_g = best_g_ff + SCORE_W'(rd_cost);
   assign special = (nb_idx_ff == start_idx) || (goal_in && (nb_idx_ff == goal_idx));

   always_comb begin
      nb_ok  = 1'b0;
      nb_idx = best_idx_ff;
      unique case (dir_ff)
         DIR_UP: begin
            nb_ok  = (best_row_ff != '0);
            nb_idx = best_idx_ff - COLS_IDX;
         end
         DIR_DOWN: begin
            nb_ok  = (best_row_ff != LAST_ROW);
            nb_idx = best_idx_ff + COLS_IDX;
         end
         DIR_LEFT: begin
            nb_ok  = (best_col_ff != '0);
            nb_idx = best_idx_ff - IDX_W'(1);
         end
         DIR_RIGHT: begin
            nb_ok  = (best_col_ff != LAST_COL);
            nb_idx = best_idx_ff + IDX_W'(1);
         end
         default: begin
            nb_ok  = 1'b0;
            nb_idx = best_idx_ff;
         end
      endcase
   end

   // step back against the stored move
   always_comb begin
      bt_ok  = 1'b0;
      bt_idx = cur_idx_ff;
      bt_row = cur_row_ff;
      bt_col = cur_col_ff;
      unique case (rd_parent)
         DIR_UP: begin
            bt_ok  = (cur_row_ff != LAST_ROW);
            bt_idx = cur_idx_ff + COLS_IDX;
            bt_row = cur_row_ff + RW'(1);
         end
         DIR_DOWN: begin
            bt_ok  = (cur_row_ff != '0);
            bt_idx = cur_idx_ff - COLS_IDX;
            bt_row = cur_row_ff - RW'(1);
         end
         DIR_LEFT: begin
            bt_ok  = (cur_col_ff != LAST_COL);
            bt_idx = cur_idx_ff + IDX_W'(1);
            bt_col = cur_col_ff + CW'(1);
         end
         DIR_RIGHT: begin
            bt_ok  = (cur_col_ff != '0);
            bt_idx = cur_idx_ff - IDX_W'(1);
            bt_col = cur_col_ff - CW'(1);
         end
         default: begin
            bt_ok = 1'b0;
         end
      endcase
   end

   // parent of a read cell, wrapping to the five port bits
   always_comb begin
      rd_parent_ok = 1'b1;
      rd_prow      = row_ff;
      rd_pcol      = col_ff;
      unique case (rd_parent)
         DIR_UP:    rd_prow = row_ff + POS_W'(1);
         DIR_DOWN: begin
            rd_parent_ok = (row_ff != '0);
            rd_prow      = row_ff - POS_W'(1);
         end
         DIR_LEFT:  rd_pcol = col_ff + POS_W'(1);
         DIR_RIGHT: begin
            rd_parent_ok = (col_ff != '0);
            rd_pcol      = col_ff - POS_W'(1);
         end
         default:   rd_parent_ok = 1'b0;
      endcase
   end

   assign is_start_cell = start_ok && (item_idx == start_idx);

   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      cost_in     = cost_ff;
      wall_in     = wall_ff;
      sc_idx_in   = sc_idx_ff;
      sc_row_in   = sc_row_ff;
      sc_col_in   = sc_col_ff;
      iss_done_in = iss_done_ff;
      dv_in       = 1'b0;
      d_idx_in    = sc_idx_ff;
      d_row_in    = sc_row_ff;
      d_col_in    = sc_col_ff;
      found_in    = found_ff;
      best_idx_in = best_idx_ff;
      best_row_in = best_row_ff;
      best_col_in = best_col_ff;
      best_f_in   = best_f_ff;
      best_g_in   = best_g_ff;
      dir_in      = dir_ff;
      nb_idx_in   = nb_idx_ff;
      visited_in  = visited_ff;
      plen_in     = plen_ff;
      pcost_in    = pcost_ff;
      cur_idx_in  = cur_idx_ff;
      cur_row_in  = cur_row_ff;
      cur_col_in  = cur_col_ff;
      steps_in    = steps_ff;
      respond     = 1'b0;
      resp_status = STAT_DONE_OK;
      we          = '0;
      waddr       = item_idx;
      wr_cost     = COST_BITS'(cost_ff);
      wr_wall     = wall_ff;
      wr_score    = trial_g;
      wr_parent   = dir_ff;
      wr_scored   = 1'b1;
      wr_open     = 1'b1;
      wr_path     = 1'b1;
      raddr       = item_idx;

      unique case (state_ff)
         // flag arrays start out zero: one clearing pass after reset
         S_INIT: begin
            waddr        = sc_idx_ff;
            we.scored_we = 1'b1;
            we.open_we   = 1'b1;
            we.path_we   = 1'b1;
            wr_scored    = 1'b0;
            wr_open      = 1'b0;
            wr_path      = 1'b0;
            sc_idx_in    = sc_idx_ff + IDX_W'(1);
            if (sc_idx_ff == LAST_IDX) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               op_in   = req_opcode;
               row_in  = req_cell_row;
               col_in  = req_cell_col;
               cost_in = req_cell_cost;
               wall_in = req_cell_blocked;
               unique case (req_opcode)
                  OP_LOAD: state_in = S_LOAD;
                  OP_READ: state_in = S_READ;
                  OP_RUN: begin
                     state_in   = S_CLEAR;
                     sc_idx_in  = '0;
                     visited_in = '0;
                     plen_in    = '0;
                     pcost_in   = '0;
                  end
                  default: state_in = S_LOAD;
               endcase
            end
         end
         S_LOAD: begin
            we.cell_we = (op_ff == OP_LOAD) && item_in_grid;
            respond    = 1'b1;
            state_in   = S_IDLE;
         end
         S_READ: begin
            state_in = S_READ_WAIT;
         end
         S_READ_WAIT: begin
            respond  = 1'b1;
            state_in = S_IDLE;
         end
         S_CLEAR: begin
            waddr        = sc_idx_ff;
            we.scored_we = 1'b1;
            we.open_we   = 1'b1;
            we.path_we   = 1'b1;
            wr_scored    = 1'b0;
            wr_open      = 1'b0;
            wr_path      = 1'b0;
            sc_idx_in    = sc_idx_ff + IDX_W'(1);
            if (sc_idx_ff == LAST_IDX) begin
               if (start_ok) begin
                  state_in = S_SEED;
               end else begin
                  respond     = 1'b1;
                  resp_status = STAT_NO_START;
                  state_in    = S_IDLE;
               end
            end
         end
         S_SEED: begin
            waddr        = start_idx;
            we.score_we  = 1'b1;
            we.scored_we = 1'b1;
            we.open_we   = 1'b1;
            wr_score     = '0;
            state_in     = S_SCAN;
            sc_idx_in    = '0;
            sc_row_in    = '0;
            sc_col_in    = '0;
            iss_done_in  = 1'b0;
            found_in     = 1'b0;
         end
         S_SCAN: begin
            raddr = sc_idx_ff;
            if (!iss_done_ff) begin
               dv_in     = 1'b1;
               sc_idx_in = sc_idx_ff + IDX_W'(1);
               if (sc_col_ff == LAST_COL) begin
                  sc_col_in = '0;
                  sc_row_in = sc_row_ff + RW'(1);
               end else begin
                  sc_col_in = sc_col_ff + CW'(1);
               end
               if (sc_idx_ff == LAST_IDX) begin
                  iss_done_in = 1'b1;
               end
            end
            // ascending sweep with strict compare keeps the lowest index on ties
            if (dv_ff && rd_open && (!found_ff || (scan_f < best_f_ff))) begin
               found_in    = 1'b1;
               best_idx_in = d_idx_ff;
               best_row_in = d_row_ff;
               best_col_in = d_col_ff;
               best_f_in   = scan_f;
               best_g_in   = rd_score;
            end
            if (iss_done_ff && !dv_ff) begin
               if (!found_ff || (goal_in && (best_idx_ff == goal_idx))) begin
                  state_in = S_FIN_ISSUE;
               end else begin
                  state_in = S_EXPAND;
               end
            end
         end
         S_EXPAND: begin
            waddr      = best_idx_ff;
            we.open_we = 1'b1;
            wr_open    = 1'b0;
            dir_in     = DIR_UP;
            state_in   = S_NB_ISSUE;
         end
         S_NB_ISSUE: begin
            raddr     = nb_idx;
            nb_idx_in = nb_idx;
            if (nb_ok) begin
               state_in = S_NB_WAIT;
            end else if (dir_ff == DIR_RIGHT) begin
               state_in    = S_SCAN;
               sc_idx_in   = '0;
               sc_row_in   = '0;
               sc_col_in   = '0;
               iss_done_in = 1'b0;
               found_in    = 1'b0;
            end else begin
               dir_in = dir_ff + 2'd1;
            end
         end
         S_NB_WAIT: begin
            waddr = nb_idx_ff;
            if ((!rd_wall || special) && (!rd_scored || (trial_g < rd_score))) begin
               we.score_we  = 1'b1;
               we.parent_we = 1'b1;
               we.scored_we = 1'b1;
               we.open_we   = 1'b1;
               if (!rd_scored && !special && (visited_ff != CNT_MAX)) begin
                  visited_in = visited_ff + CNT_W'(1);
               end
            end
            if (dir_ff == DIR_RIGHT) begin
               state_in    = S_SCAN;
               sc_idx_in   = '0;
               sc_row_in   = '0;
               sc_col_in   = '0;
               iss_done_in = 1'b0;
               found_in    = 1'b0;
            end else begin
               dir_in   = dir_ff + 2'd1;
               state_in = S_NB_ISSUE;
            end
         end
         S_FIN_ISSUE: begin
            raddr = goal_idx;
            if (goal_in) begin
               state_in = S_FIN_WAIT;
            end else begin
               respond     = 1'b1;
               resp_status = STAT_NO_PATH;
               state_in    = S_IDLE;
            end
         end
         S_FIN_WAIT: begin
            if (rd_scored) begin
               pcost_in   = (32'(rd_score) > 32'(PCOST_MAX)) ? PCOST_MAX
                                                             : PCOST_W'(rd_score);
               cur_idx_in = goal_idx;
               cur_row_in = RW'(cfg.goal_row);
               cur_col_in = CW'(cfg.goal_col);
               steps_in   = '0;
               state_in   = S_BT_ISSUE;
            end else begin
               respond     = 1'b1;
               resp_status = STAT_NO_PATH;
               state_in    = S_IDLE;
            end
         end
         S_BT_ISSUE: begin
            raddr    = cur_idx_ff;
            state_in = S_BT_WAIT;
         end
         S_BT_WAIT: begin
            waddr = cur_idx_ff;
            if ((steps_ff == STEP_MAX) || (cur_idx_ff == start_idx) || !rd_scored) begin
               respond     = 1'b1;
               resp_status = STAT_PATH_FOUND;
               state_in    = S_IDLE;
            end else begin
               if (cur_idx_ff != goal_idx) begin
                  we.path_we = 1'b1;
                  if (plen_ff != CNT_MAX) begin
                     plen_in = plen_ff + CNT_W'(1);
                  end
               end
               if (bt_ok) begin
                  cur_idx_in = bt_idx;
                  cur_row_in = bt_row;
                  cur_col_in = bt_col;
                  steps_in   = steps_ff + (IDX_W+1)'(1);
                  state_in   = S_BT_ISSUE;
               end else begin
                  respond     = 1'b1;
                  resp_status = STAT_PATH_FOUND;
                  state_in    = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_strobe_in  = respond;
      rsp_status_in  = resp_status;
      rsp_visited_in = '0;
      rsp_plen_in    = '0;
      rsp_pcost_in   = '0;
      rsp_prow_in    = '0;
      rsp_pcol_in    = '0;
      rsp_hasp_in    = 1'b0;
      rsp_onp_in     = 1'b0;
      if (op_ff == OP_RUN) begin
         rsp_visited_in = visited_in;
         rsp_plen_in    = plen_in;
         rsp_pcost_in   = pcost_in;
      end
      if ((state_ff == S_READ_WAIT) && item_in_grid) begin
         rsp_hasp_in = rd_scored && !is_start_cell && rd_parent_ok;
         rsp_prow_in = rsp_hasp_in ? rd_prow : '0;
         rsp_pcol_in = rsp_hasp_in ? rd_pcol : '0;
         rsp_onp_in  = rd_path;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_INIT;
         sc_idx_ff     <= '0;
         iss_done_ff   <= 1'b0;
         dv_ff         <= 1'b0;
         found_ff      <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         sc_idx_ff     <= sc_idx_in;
         iss_done_ff   <= iss_done_in;
         dv_ff         <= dv_in;
         found_ff      <= found_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      row_ff         <= row_in;
      col_ff         <= col_in;
      cost_ff        <= cost_in;
      wall_ff        <= wall_in;
      sc_row_ff      <= sc_row_in;
      sc_col_ff      <= sc_col_in;
      d_idx_ff       <= d_idx_in;
      d_row_ff       <= d_row_in;
      d_col_ff       <= d_col_in;
      best_idx_ff    <= best_idx_in;
      best_row_ff    <= best_row_in;
      best_col_ff    <= best_col_in;
      best_f_ff      <= best_f_in;
      best_g_ff      <= best_g_in;
      dir_ff         <= dir_in;
      nb_idx_ff      <= nb_idx_in;
      visited_ff     <= visited_in;
      plen_ff        <= plen_in;
      pcost_ff       <= pcost_in;
      cur_idx_ff     <= cur_idx_in;
      cur_row_ff     <= cur_row_in;
      cur_col_ff     <= cur_col_in;
      steps_ff       <= steps_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_visited_ff <= rsp_visited_in;
      rsp_plen_ff    <= rsp_plen_in;
      rsp_pcost_ff   <= rsp_pcost_in;
      rsp_prow_ff    <= rsp_prow_in;
      rsp_pcol_ff    <= rsp_pcol_in;
      rsp_hasp_ff    <= rsp_hasp_in;
      rsp_onp_ff     <= rsp_onp_in;
   end

   assign busy              = (state_ff != S_IDLE);
   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_visited_count = rsp_visited_ff;
   assign rsp_path_length   = rsp_plen_ff;
   assign rsp_path_cost     = rsp_pcost_ff;
   assign rsp_parent_row    = rsp_prow_ff;
   assign rsp_parent_col    = rsp_pcol_ff;
   assign rsp_has_parent    = rsp_hasp_ff;
   assign rsp_on_path       = rsp_onp_ff;

endmodule

// ===== hw/rtl/grid_astar_path_search_top.sv =====
// top level of the grid path search block: config registers, sequencer, cell store
// uses gaps_pkg, gaps_ctrl, gaps_store and grid_astar_path_search_top_defines.svh
//
//   channel   handshake            payload
//   request   start / busy         req_opcode req_cell_row req_cell_col req_cell_cost
//                                  req_cell_blocked
//   response  rsp_strobe (1 cycle) rsp_status rsp_visited_count rsp_path_length
//                                  rsp_path_cost rsp_parent_row rsp_parent_col
//                                  rsp_has_parent rsp_on_path
//   config    csr_wen              csr_index csr_wdata
//
// load items and unknown opcodes answer from S_LOAD, unknown ones without a write,
// read items from S_READ_WAIT; a run clears the flag arrays, then each expansion takes
// a full sweep of the cells for the min-f search, closes the cell and checks the
// neighbors in turn, and the path trace reads back cell by cell, all on one port pair
// after reset a clearing pass over all cells zeroes the flag arrays with busy high
// busy stays high until the result strobe; the result strobe lasts one cycle
// and cannot be stalled
`include "grid_astar_path_search_top_defines.svh"

module grid_astar_path_search_top #(
   parameter int GRID_ROWS = gaps_pkg::DEF_GRID_ROWS,
   parameter int GRID_COLS = gaps_pkg::DEF_GRID_COLS,
   parameter int COST_BITS = gaps_pkg::DEF_COST_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [gaps_pkg::OPC_W-1:0]         req_opcode,
   input  logic [gaps_pkg::POS_W-1:0]         req_cell_row,
   input  logic [gaps_pkg::POS_W-1:0]         req_cell_col,
   input  logic [gaps_pkg::IN_COST_W-1:0]     req_cell_cost,
   input  logic                               req_cell_blocked,
   output logic                               rsp_strobe,
   output logic [1:0]                         rsp_status,
   output logic [gaps_pkg::CNT_W-1:0]         rsp_visited_count,
   output logic [gaps_pkg::CNT_W-1:0]         rsp_path_length,
   output logic [gaps_pkg::PCOST_W-1:0]       rsp_path_cost,
   output logic [gaps_pkg::POS_W-1:0]         rsp_parent_row,
   output logic [gaps_pkg::POS_W-1:0]         rsp_parent_col,
   output logic                               rsp_has_parent,
   output logic                               rsp_on_path,
   input  logic                               csr_wen,
   input  logic [gaps_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [gaps_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import gaps_pkg::*;

   localparam int CELLS   = GRID_ROWS * GRID_COLS;
   localparam int IDX_W   = $clog2(CELLS);
   localparam int SCORE_W = $clog2(CELLS * ((1 << COST_BITS) - 1) + 1);

   cfg_type                cfg_ff, cfg_in;
   mem_we_type             we;
   logic [IDX_W-1:0]       waddr, raddr;
   logic [COST_BITS-1:0]   wr_cost, rd_cost;
   logic                   wr_wall, rd_wall;
   logic [SCORE_W-1:0]     wr_score, rd_score;
   logic [1:0]             wr_parent, rd_parent;
   logic                   wr_scored, rd_scored;
   logic                   wr_open, rd_open;
   logic                   wr_path, rd_path;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         unique case (csr_index)
            CSR_START_ROW:     cfg_in.start_row     = csr_wdata;
            CSR_START_COL:     cfg_in.start_col     = csr_wdata;
            CSR_GOAL_ROW:      cfg_in.goal_row      = csr_wdata;
            CSR_GOAL_COL:      cfg_in.goal_col      = csr_wdata;
            CSR_START_PRESENT: cfg_in.start_present = csr_wdata[0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   gaps_ctrl #(
      .GRID_ROWS (GRID_ROWS),
      .GRID_COLS (GRID_COLS),
      .CELLS     (CELLS),
      .IDX_W     (IDX_W),
      .COST_BITS (COST_BITS),
      .SCORE_W   (SCORE_W)
   ) u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .start             (start),
      .busy              (busy),
      .req_opcode        (req_opcode),
      .req_cell_row      (req_cell_row),
      .req_cell_col      (req_cell_col),
      .req_cell_cost     (req_cell_cost),
      .req_cell_blocked  (req_cell_blocked),
      .we                (we),
      .waddr             (waddr),
      .wr_cost           (wr_cost),
      .wr_wall           (wr_wall),
      .wr_score          (wr_score),
      .wr_parent         (wr_parent),
      .wr_scored         (wr_scored),
      .wr_open           (wr_open),
      .wr_path           (wr_path),
      .raddr             (raddr),
      .rd_cost           (rd_cost),
      .rd_wall           (rd_wall),
      .rd_score          (rd_score),
      .rd_parent         (rd_parent),
      .rd_scored         (rd_scored),
      .rd_open           (rd_open),
      .rd_path           (rd_path),
      .rsp_strobe        (rsp_strobe),
      .rsp_status        (rsp_status),
      .rsp_visited_count (rsp_visited_count),
      .rsp_path_length   (rsp_path_length),
      .rsp_path_cost     (rsp_path_cost),
      .rsp_parent_row    (rsp_parent_row),
      .rsp_parent_col    (rsp_parent_col),
      .rsp_has_parent    (rsp_has_parent),
      .rsp_on_path       (rsp_on_path)
   );

   gaps_store #(
      .CELLS     (CELLS),
      .IDX_W     (IDX_W),
      .COST_BITS (COST_BITS),
      .SCORE_W   (SCORE_W)
   ) u_store (
      .clock     (clock),
      .we        (we),
      .waddr     (waddr),
      .wr_cost   (wr_cost),
      .wr_wall   (wr_wall),
      .wr_score  (wr_score),
      .wr_parent (wr_parent),
      .wr_scored (wr_scored),
      .wr_open   (wr_open),
      .wr_path   (wr_path),
      .raddr     (raddr),
      .rd_cost   (rd_cost),
      .rd_wall   (rd_wall),
      .rd_score  (rd_score),
      .rd_parent (rd_parent),
      .rd_scored (rd_scored),
      .rd_open   (rd_open),
      .rd_path   (rd_path)
   );

   // an accepted transfer always leaves the sequencer busy on the following cycle
   `GAPS_ASSERT_NXT(a_accept_busy, start && !busy, busy)
   // a result only appears once the sequencer is back in idle
   `GAPS_ASSERT_IMP(a_strobe_idle, rsp_strobe, !busy)
   // a result strobe never repeats back to back: each item needs its own trip out of idle
   `GAPS_ASSERT_NXT(a_strobe_gap, rsp_strobe, !rsp_strobe)
   // only read items carry parent data
   `GAPS_ASSERT_IMP(a_parent_zero_run, rsp_strobe && (rsp_visited_count != '0), !rsp_has_parent)

endmodule
